// File: rtl/bfsa_pkg.sv
// Shared types and codes for the best-fit slice allocator.
`default_nettype none
package bfsa_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_PUBLISH = 2'd1;
    localparam logic [1:0] CMD_KREL = 2'd2;
    localparam logic [1:0] CMD_UREL = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO = 3'd1;
    localparam logic [2:0] ST_NOFIT = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam int FL_FREE = 0;
    localparam int FL_ACCT = 1;
    localparam int FL_KERN = 2;
    localparam int FL_USER = 3;

    localparam logic [31:0] POOL_RESET = 32'd65536;

    typedef struct packed {
        logic [3:0]  flags;
        logic [31:0] length;
        logic [31:0] start;
    } entry_t;

endpackage
`default_nettype wire

// File: rtl/best_fit_slice_allocator_unit.sv
// Best-fit slice allocator: slice table in one memory, walked by a small sequencer.
//
// Input stream s_*: one command per transfer (allocate, publish, kernel release,
// user release). Output stream m_*: exactly one result per command, in order.
// cfg_we/cfg_wdata write the pool size; the table is rebuilt as one free slice
// and the accounted total is cleared. Write it only while the block is idle.
// The table lives in a single-port-write, registered-read memory; every walk
// over it (best-fit scan, offset lookup, shift on split or merge) touches one
// entry per cycle. An allocate scans the whole table and, on a split, shifts
// the entries above the best fit up; a publish or release scans up to its
// slice and, on a merge, shifts the entries above it down. s_tready is low
// meanwhile. After reset (and after a pool size write) entry 0 is rebuilt
// before s_tready rises. The result sits in an output register; a stalled
// receiver holds the finished command, and the block can already take the
// next command, which waits at its end for the register to drain.
`default_nettype none
module best_fit_slice_allocator_unit #(
    parameter int MAX_SLICES = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // command[1:0], request_bytes[33:2], charge_quota[34], slice_offset[66:35]
    input  wire logic [71:0]   s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // status[2:0], result_offset[34:3], result_length[66:35],
    // accounted_bytes[98:67], slice_freed[99]
    output logic [103:0]       m_tdata
);
    import bfsa_pkg::*;

    localparam int IW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int CW = $clog2(MAX_SLICES + 2);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SLICES);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_ALLOC_DEC, S_SHIFT_UP, S_SPLIT_WR, S_ALLOC_WR,
        S_FR_NEXT, S_FR_PREV, S_DROP, S_DONE
    } state_t;

    entry_t mem [MAX_SLICES];
    entry_t rdata_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [32:0]   need_reg, need_next;
    logic          charge_reg, charge_next;
    logic [31:0]   off_reg, off_next;
    logic [31:0]   pool_reg;
    logic [31:0]   acct_reg, acct_next;
    logic          init_reg, init_next;
    logic          found_reg, found_next;
    logic [31:0]   blen_reg, blen_next;
    logic [31:0]   bstart_reg, bstart_next;
    logic [31:0]   clen_reg, clen_next;
    logic [31:0]   cstart_reg, cstart_next;
    logic          to_prev_reg, to_prev_next;
    logic [2:0]    st_reg, st_next;
    logic [31:0]   roff_reg, roff_next;
    logic [31:0]   rlen_reg, rlen_next;
    logic          freed_reg, freed_next;
    logic          m_valid_reg, m_valid_next;
    logic [103:0]  m_data_reg, m_data_next;

    logic          wr_en;
    logic [CW-1:0] wr_idx;
    entry_t        wr_data;

    entry_t        e;
    logic          last;
    logic [3:0]    f;
    logic [32:0]   acc_sum;

    assign s_tready = (state_reg == S_IDLE) && !init_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign e        = rdata_reg;
    assign last     = (ptr_reg + ONE_C) >= cnt_reg;
    assign acc_sum  = {1'b0, acct_reg} + {1'b0, need_reg[31:0]};

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[ptr_next[IW-1:0]];
        if (wr_en) begin
            mem[wr_idx[IW-1:0]] <= wr_data;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        cmd_next     = cmd_reg;
        need_next    = need_reg;
        charge_next  = charge_reg;
        off_next     = off_reg;
        acct_next    = acct_reg;
        init_next    = init_reg;
        found_next   = found_reg;
        blen_next    = blen_reg;
        bstart_next  = bstart_reg;
        clen_next    = clen_reg;
        cstart_next  = cstart_reg;
        to_prev_next = to_prev_reg;
        st_next      = st_reg;
        roff_next    = roff_reg;
        rlen_next    = rlen_reg;
        freed_next   = freed_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        wr_idx       = ptr_reg;
        wr_data      = e;
        f            = e.flags;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (init_reg) begin
                    wr_en   = 1'b1;
                    wr_idx  = '0;
                    wr_data = '{flags: 4'b0001, length: pool_reg, start: 32'd0};
                    init_next = 1'b0;
                end else if (s_tvalid) begin
                    cmd_next    = s_tdata[1:0];
                    need_next   = ({1'b0, s_tdata[33:2]} + 33'd7) & ~33'd7;
                    charge_next = s_tdata[34];
                    off_next    = s_tdata[66:35];
                    ptr_next    = '0;
                    found_next  = 1'b0;
                    st_next     = ST_OK;
                    roff_next   = '0;
                    rlen_next   = '0;
                    freed_next  = 1'b0;
                    if (s_tdata[1:0] == CMD_ALLOC && s_tdata[33:2] == 32'd0) begin
                        st_next    = ST_ZERO;
                        state_next = S_DONE;
                    end else if (s_tdata[1:0] == CMD_UREL && s_tdata[66:35] == pool_reg) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (cmd_reg == CMD_ALLOC) begin
                    if (e.flags[FL_FREE] && {1'b0, e.length} >= need_reg &&
                        (!found_reg || e.length < blen_reg)) begin
                        found_next  = 1'b1;
                        idx_next    = ptr_reg;
                        blen_next   = e.length;
                        bstart_next = e.start;
                    end
                    if (last) begin
                        state_next = S_ALLOC_DEC;
                    end else begin
                        ptr_next = ptr_reg + ONE_C;
                    end
                end else if (!e.flags[FL_FREE] && e.start == off_reg) begin
                    state_next = S_DONE;
                    case (cmd_reg)
                        CMD_PUBLISH: begin
                            if (!e.flags[FL_KERN]) begin
                                st_next = ST_UNKNOWN;
                            end else begin
                                wr_en     = 1'b1;
                                wr_data   = e;
                                wr_data.flags[FL_USER] = 1'b1;
                                roff_next = e.start;
                                rlen_next = e.length;
                            end
                        end
                        default: begin
                            if ((cmd_reg == CMD_KREL && !e.flags[FL_KERN]) ||
                                (cmd_reg == CMD_UREL && !e.flags[FL_USER])) begin
                                st_next = ST_UNKNOWN;
                            end else begin
                                if (cmd_reg == CMD_KREL) begin
                                    f[FL_KERN] = 1'b0;
                                    if (e.flags[FL_ACCT]) begin
                                        if (acct_reg >= e.length) begin
                                            acct_next = acct_reg - e.length;
                                        end
                                        f[FL_ACCT] = 1'b0;
                                    end
                                end else begin
                                    f[FL_USER] = 1'b0;
                                end
                                if (f[FL_KERN] || f[FL_USER]) begin
                                    wr_en   = 1'b1;
                                    wr_data = e;
                                    wr_data.flags = f;
                                end else begin
                                    freed_next  = 1'b1;
                                    idx_next    = ptr_reg;
                                    clen_next   = e.length;
                                    cstart_next = e.start;
                                    ptr_next    = ptr_reg + ONE_C;
                                    state_next  = S_FR_NEXT;
                                end
                            end
                        end
                    endcase
                end else if (last) begin
                    st_next    = ST_UNKNOWN;
                    state_next = S_DONE;
                end else begin
                    ptr_next = ptr_reg + ONE_C;
                end
            end
            S_ALLOC_DEC: begin
                if (!found_reg) begin
                    st_next    = ST_NOFIT;
                    state_next = S_DONE;
                end else if ({1'b0, blen_reg} > need_reg) begin
                    if (cnt_reg >= MAX_C) begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end else if ((cnt_reg - ONE_C) > idx_reg) begin
                        ptr_next   = cnt_reg - ONE_C;
                        state_next = S_SHIFT_UP;
                    end else begin
                        state_next = S_SPLIT_WR;
                    end
                end else begin
                    state_next = S_ALLOC_WR;
                end
            end
            S_SHIFT_UP: begin
                wr_en  = 1'b1;
                wr_idx = ptr_reg + ONE_C;
                if ((ptr_reg - ONE_C) > idx_reg) begin
                    ptr_next = ptr_reg - ONE_C;
                end else begin
                    state_next = S_SPLIT_WR;
                end
            end
            S_SPLIT_WR: begin
                wr_en   = 1'b1;
                wr_idx  = idx_reg + ONE_C;
                wr_data = '{flags: 4'b0001, length: blen_reg - need_reg[31:0],
                            start: bstart_reg + need_reg[31:0]};
                cnt_next   = cnt_reg + ONE_C;
                state_next = S_ALLOC_WR;
            end
            S_ALLOC_WR: begin
                wr_en   = 1'b1;
                wr_idx  = idx_reg;
                wr_data = '{flags: {2'b01, charge_reg, 1'b0}, length: need_reg[31:0],
                            start: bstart_reg};
                roff_next = bstart_reg;
                rlen_next = need_reg[31:0];
                if (charge_reg) begin
                    acct_next = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                end
                state_next = S_DONE;
            end
            S_FR_NEXT: begin
                if ((idx_reg + ONE_C) < cnt_reg && e.flags[FL_FREE]) begin
                    clen_next    = clen_reg + e.length;
                    ptr_next     = idx_reg + CW'(2);
                    to_prev_next = 1'b1;
                    state_next   = S_DROP;
                end else begin
                    ptr_next   = idx_reg - ONE_C;
                    state_next = S_FR_PREV;
                end
            end
            S_FR_PREV: begin
                wr_en = 1'b1;
                if (idx_reg != '0 && e.flags[FL_FREE]) begin
                    wr_idx       = idx_reg - ONE_C;
                    wr_data      = '{flags: 4'b0001, length: e.length + clen_reg,
                                     start: e.start};
                    ptr_next     = idx_reg + ONE_C;
                    to_prev_next = 1'b0;
                    state_next   = S_DROP;
                end else begin
                    wr_idx     = idx_reg;
                    wr_data    = '{flags: 4'b0001, length: clen_reg, start: cstart_reg};
                    state_next = S_DONE;
                end
            end
            S_DROP: begin
                if (ptr_reg < cnt_reg) begin
                    wr_en    = 1'b1;
                    wr_idx   = ptr_reg - ONE_C;
                    ptr_next = ptr_reg + ONE_C;
                end else begin
                    cnt_next = cnt_reg - ONE_C;
                    if (to_prev_reg) begin
                        ptr_next   = idx_reg - ONE_C;
                        state_next = S_FR_PREV;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, freed_reg, acct_reg, rlen_reg, roff_reg, st_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we) begin
            acct_next = '0;
            cnt_next  = ONE_C;
            init_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= ONE_C;
            acct_reg    <= '0;
            init_reg    <= 1'b1;
            pool_reg    <= POOL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            acct_reg    <= acct_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                pool_reg <= {cfg_wdata[31:3], 3'b000};
            end
        end
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        cmd_reg     <= cmd_next;
        need_reg    <= need_next;
        charge_reg  <= charge_next;
        off_reg     <= off_next;
        found_reg   <= found_next;
        blen_reg    <= blen_next;
        bstart_reg  <= bstart_next;
        clen_reg    <= clen_next;
        cstart_reg  <= cstart_next;
        to_prev_reg <= to_prev_next;
        st_reg      <= st_next;
        roff_reg    <= roff_next;
        rlen_reg    <= rlen_next;
        freed_reg   <= freed_next;
        m_data_reg  <= m_data_next;
    end

endmodule
`default_nettype wire
